// ----- design/dsc_pkg.sv -----
// ----------------------------------------------------------------------------
// dsc_pkg: shared types and tables of the day serial converter
// Microcode format, step codes, condition and operation codes, month lengths.
// ----------------------------------------------------------------------------
package dsc_pkg;

	localparam int SERIAL_W = 22;
	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;

	localparam logic [YEAR_W-1:0]   FIRST_YEAR    = 14'd1900;
	localparam logic [SERIAL_W-1:0] SERIAL_OFFSET = 22'd2;
	localparam logic [MONTH_W-1:0]  LAST_MONTH    = 4'd12;

	// microprogram step address
	typedef logic [2:0] step_t;

	localparam step_t S_WAIT = 3'd0;
	localparam step_t S_LOW  = 3'd1;
	localparam step_t S_YFIT = 3'd2;
	localparam step_t S_YEND = 3'd3;
	localparam step_t S_MFIT = 3'd4;
	localparam step_t S_OUT  = 3'd5;
	localparam step_t S_INV  = 3'd6;

	typedef enum logic [2:0] {
		C_IN_VALID,
		C_SER_LOW,
		C_YFIT_OR_OVER,
		C_YEAR_OVER,
		C_MFIT,
		C_OUT_FREE
	} cond_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_YSUB,
		OP_MSUB,
		OP_EMIT,
		OP_EMIT_INV
	} op_t;

	typedef struct packed {
		cond_t cond;
		step_t next_t;
		op_t   op_t_sel;
		step_t next_f;
		op_t   op_f_sel;
	} ctrl_word_t;

	typedef struct packed {
		logic ser_low;
		logic yfit_or_over;
		logic year_over;
		logic mfit;
	} dp_status_t;

	function automatic ctrl_word_t ucode_rom(input step_t pc);
		ctrl_word_t cw;
		unique case (pc)
			S_WAIT:  cw = '{C_IN_VALID,     S_LOW,  OP_LOAD,     S_WAIT, OP_NONE};
			S_LOW:   cw = '{C_SER_LOW,      S_INV,  OP_NONE,     S_YFIT, OP_NONE};
			S_YFIT:  cw = '{C_YFIT_OR_OVER, S_YEND, OP_NONE,     S_YFIT, OP_YSUB};
			S_YEND:  cw = '{C_YEAR_OVER,    S_INV,  OP_NONE,     S_MFIT, OP_NONE};
			S_MFIT:  cw = '{C_MFIT,         S_OUT,  OP_NONE,     S_MFIT, OP_MSUB};
			S_OUT:   cw = '{C_OUT_FREE,     S_WAIT, OP_EMIT,     S_OUT,  OP_NONE};
			S_INV:   cw = '{C_OUT_FREE,     S_WAIT, OP_EMIT_INV, S_INV,  OP_NONE};
			default: cw = '{C_IN_VALID,     S_WAIT, OP_NONE,     S_WAIT, OP_NONE};
		endcase
		return cw;
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		case (m) inside
			4'd2:                      len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

// ----- design/dsc_ucode_seq.sv -----
// ----------------------------------------------------------------------------
// dsc_ucode_seq: microcode sequencer
// Step counter, control store and two-way conditional branch per step.
// ----------------------------------------------------------------------------
module dsc_ucode_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                out_free,
	input  dsc_pkg::dp_status_t status,
	output dsc_pkg::op_t        op,
	output logic                idle
);

	dsc_pkg::step_t     pc_q;
	dsc_pkg::ctrl_word_t cw;
	logic               hit;

	assign cw = dsc_pkg::ucode_rom(pc_q);

	always_comb begin
		unique case (cw.cond)
			dsc_pkg::C_IN_VALID:     hit = in_valid;
			dsc_pkg::C_SER_LOW:      hit = status.ser_low;
			dsc_pkg::C_YFIT_OR_OVER: hit = status.yfit_or_over;
			dsc_pkg::C_YEAR_OVER:    hit = status.year_over;
			dsc_pkg::C_MFIT:         hit = status.mfit;
			dsc_pkg::C_OUT_FREE:     hit = out_free;
			default:                 hit = 1'b0;
		endcase
	end

	assign op   = hit ? cw.op_t_sel : cw.op_f_sel;
	assign idle = (pc_q == dsc_pkg::S_WAIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= dsc_pkg::S_WAIT;
		end else begin
			pc_q <= hit ? cw.next_t : cw.next_f;
		end
	end

endmodule

// ----- design/dsc_datapath.sv -----
// ----------------------------------------------------------------------------
// dsc_datapath: day counter, year and month registers, output register
// Executes one microcode operation per cycle.
// ----------------------------------------------------------------------------
module dsc_datapath #(
	parameter int LAST_YEAR = 9999
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dsc_pkg::op_t                        op,
	input  logic [dsc_pkg::SERIAL_W-1:0]        serial,
	input  logic                                out_stall,
	output dsc_pkg::dp_status_t                 status,
	output logic                                out_free,
	output logic                                out_valid,
	output logic [dsc_pkg::YEAR_W-1:0]          year_out,
	output logic [dsc_pkg::MONTH_W-1:0]         month_out,
	output logic [dsc_pkg::DAY_W-1:0]           day_out,
	output logic                                invalid
);

	localparam logic [dsc_pkg::YEAR_W-1:0] LAST_YR = dsc_pkg::YEAR_W'(LAST_YEAR);

	logic [dsc_pkg::SERIAL_W-1:0] days_q;
	logic [dsc_pkg::YEAR_W-1:0]   year_q;
	logic [dsc_pkg::MONTH_W-1:0]  month_q;
	logic [1:0]                   mod4_q;
	logic [6:0]                   mod100_q;
	logic [8:0]                   mod400_q;
	logic                         low_q;
	logic                         out_valid_q;

	logic                         leap;
	logic [8:0]                   ylen;
	logic [dsc_pkg::DAY_W-1:0]    mlen;
	logic                         yfit;

	// gregorian rule from the running year residues
	assign leap = (mod400_q == 9'd0) || ((mod100_q != 7'd0) && (mod4_q == 2'd0));
	assign ylen = leap ? 9'd366 : 9'd365;
	assign mlen = dsc_pkg::month_len(month_q, leap);
	assign yfit = (days_q <= {{(dsc_pkg::SERIAL_W-9){1'b0}}, ylen});

	assign status.ser_low      = low_q;
	assign status.year_over    = (year_q > LAST_YR);
	assign status.yfit_or_over = yfit || status.year_over;
	assign status.mfit         = (month_q == dsc_pkg::LAST_MONTH) ||
		(days_q <= {{(dsc_pkg::SERIAL_W-dsc_pkg::DAY_W){1'b0}}, mlen});

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk) begin
		case (op)
			dsc_pkg::OP_LOAD: begin
				days_q   <= serial - dsc_pkg::SERIAL_OFFSET;
				low_q    <= (serial <= dsc_pkg::SERIAL_OFFSET);
				year_q   <= dsc_pkg::FIRST_YEAR;
				month_q  <= 4'd1;
				mod4_q   <= 2'd0;
				mod100_q <= 7'd0;
				mod400_q <= 9'd300;
			end
			dsc_pkg::OP_YSUB: begin
				days_q   <= days_q - {{(dsc_pkg::SERIAL_W-9){1'b0}}, ylen};
				year_q   <= year_q + 14'd1;
				mod4_q   <= mod4_q + 2'd1;
				mod100_q <= (mod100_q == 7'd99) ? 7'd0 : mod100_q + 7'd1;
				mod400_q <= (mod400_q == 9'd399) ? 9'd0 : mod400_q + 9'd1;
			end
			dsc_pkg::OP_MSUB: begin
				days_q  <= days_q - {{(dsc_pkg::SERIAL_W-dsc_pkg::DAY_W){1'b0}}, mlen};
				month_q <= month_q + 4'd1;
			end
			dsc_pkg::OP_EMIT: begin
				year_out  <= year_q;
				month_out <= month_q;
				day_out   <= days_q[dsc_pkg::DAY_W-1:0];
				invalid   <= 1'b0;
			end
			dsc_pkg::OP_EMIT_INV: begin
				year_out  <= '0;
				month_out <= '0;
				day_out   <= '0;
				invalid   <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op == dsc_pkg::OP_EMIT || op == dsc_pkg::OP_EMIT_INV) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- design/day_serial_to_calendar_date.sv -----
// ----------------------------------------------------------------------------
// day_serial_to_calendar_date: day serial number to gregorian date
//
//   channel  handshake            payload
//   in       in_valid / in_stall  serial[21:0]
//   out      out_valid/ out_stall year_out[13:0] month_out[3:0] day_out[4:0] invalid
//
// One request at a time: once a request is taken, the sequencer tests for a
// serial below 3, walks Y years from 1900, then M months (at most 11), and
// registers the result; a serial below 3 or a year past LAST_YEAR is invalid.
// The next request is taken the cycle after the result is registered; a
// result waiting in the output register stalls the sequencer only when a
// second result is ready. Reset clears the step counter and the output valid.
// ----------------------------------------------------------------------------
module day_serial_to_calendar_date #(
	parameter int LAST_YEAR = 9999
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [dsc_pkg::SERIAL_W-1:0]  serial,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [dsc_pkg::YEAR_W-1:0]    year_out,
	output logic [dsc_pkg::MONTH_W-1:0]   month_out,
	output logic [dsc_pkg::DAY_W-1:0]     day_out,
	output logic                          invalid
);

	dsc_pkg::op_t        op;
	dsc_pkg::dp_status_t status;
	logic                out_free;
	logic                idle;

	dsc_ucode_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.status   (status),
		.op       (op),
		.idle     (idle)
	);

	dsc_datapath #(
		.LAST_YEAR (LAST_YEAR)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.serial    (serial),
		.out_stall (out_stall),
		.status    (status),
		.out_free  (out_free),
		.out_valid (out_valid),
		.year_out  (year_out),
		.month_out (month_out),
		.day_out   (day_out),
		.invalid   (invalid)
	);

	assign in_stall = !idle;

	// an invalid result carries no date
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && invalid |-> year_out == '0 && month_out == '0 && day_out == '0)
		else $error("invalid result with nonzero date");

	// a valid result is a date within the supported range
	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !invalid |-> month_out >= 4'd1 && month_out <= 4'd12 &&
			day_out >= 5'd1 && year_out >= dsc_pkg::FIRST_YEAR &&
			year_out <= dsc_pkg::YEAR_W'(LAST_YEAR))
		else $error("result date out of range");

	// the sequencer leaves the wait step once a request is taken
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while previous one still in work");

endmodule

// ----- test/tb_day_serial_to_calendar_date.sv -----
// ----------------------------------------------------------------------------
// tb_day_serial_to_calendar_date: self-checking bench of the serial converter
// Sends day serial numbers through the valid/stall request channel and checks
// each year, month, day and invalid flag against a calendar walk of its own.
// Directed dates cover the low and high ends and the leap rules, random
// serials follow. Both channels take random idle bursts.
// ----------------------------------------------------------------------------
module tb_day_serial_to_calendar_date;

	localparam int LAST_YEAR = 9999;
	localparam int BASE_YEAR = 1900;
	localparam int MAX_SERIAL = 4194303;

	typedef struct packed {
		logic [dsc_pkg::YEAR_W-1:0]  year;
		logic [dsc_pkg::MONTH_W-1:0] month;
		logic [dsc_pkg::DAY_W-1:0]   day;
		logic                        invalid;
	} date_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [dsc_pkg::SERIAL_W-1:0]  serial = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [dsc_pkg::YEAR_W-1:0]    year_out;
	logic [dsc_pkg::MONTH_W-1:0]   month_out;
	logic [dsc_pkg::DAY_W-1:0]     day_out;
	logic                          invalid;

	date_t pending_dates[$];
	int    mismatches = 0;
	bit    idle_on = 1'b1;
	int    stall_left = 0;
	int    last_valid_serial;

	day_serial_to_calendar_date #(
		.LAST_YEAR(LAST_YEAR)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.serial(serial),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.year_out(year_out),
		.month_out(month_out),
		.day_out(day_out),
		.invalid(invalid)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit is_leap(input int y);
		return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
	endfunction

	function automatic int month_days(input int m, input bit leap);
		if (m == 2)
			return leap ? 29 : 28;
		if (m == 4 || m == 6 || m == 9 || m == 11)
			return 30;
		return 31;
	endfunction

	// serial that lands on the given date
	function automatic int serial_of(input int y, input int m, input int d);
		int total;
		total = 2 + d;
		for (int yy = BASE_YEAR; yy < y; yy++)
			total += is_leap(yy) ? 366 : 365;
		for (int mm = 1; mm < m; mm++)
			total += month_days(mm, is_leap(y));
		return total;
	endfunction

	function automatic date_t to_calendar(input logic [dsc_pkg::SERIAL_W-1:0] s);
		date_t r;
		int    left;
		int    yr;
		int    mo;
		int    len;
		bit    leap;
		r = '0;
		r.invalid = 1'b1;
		if (s < 3)
			return r;
		left = int'(s) - 2;
		yr = BASE_YEAR;
		while (yr <= LAST_YEAR) begin
			len = is_leap(yr) ? 366 : 365;
			if (left <= len)
				break;
			left -= len;
			yr++;
		end
		if (yr > LAST_YEAR)
			return r;
		leap = is_leap(yr);
		mo = 1;
		while (mo < 12 && left > month_days(mo, leap)) begin
			left -= month_days(mo, leap);
			mo++;
		end
		r.year = yr[dsc_pkg::YEAR_W-1:0];
		r.month = mo[dsc_pkg::MONTH_W-1:0];
		r.day = left[dsc_pkg::DAY_W-1:0];
		r.invalid = 1'b0;
		return r;
	endfunction

	// receiver side: random stall bursts of random length
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 2);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		date_t got;
		date_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{year_out, month_out, day_out, invalid};
			if (pending_dates.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: year %0d month %0d day %0d invalid %0b",
						got.year, got.month, got.day, got.invalid);
			end else begin
				want = pending_dates.pop_front();
				if (got.year !== want.year || got.month !== want.month ||
					got.day !== want.day || got.invalid !== want.invalid) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d-%0d-%0d inv %0b, got %0d-%0d-%0d inv %0b",
							want.year, want.month, want.day, want.invalid,
							got.year, got.month, got.day, got.invalid);
				end
			end
		end
	end

	task automatic send_serial(input int s);
		logic [dsc_pkg::SERIAL_W-1:0] value;
		value = s[dsc_pkg::SERIAL_W-1:0];
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		serial <= value;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_dates.push_back(to_calendar(value));
	endtask

	task automatic wait_all_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_dates.size() > 0)
			@(posedge clk);
	endtask

	task automatic test_low_serials();
		send_serial(0);
		send_serial(1);
		send_serial(2);
		send_serial(3);
		send_serial(4);
	endtask

	task automatic test_leap_rules();
		send_serial(serial_of(1900, 1, 31));
		send_serial(serial_of(1900, 2, 1));
		send_serial(serial_of(1900, 2, 28));
		send_serial(serial_of(1900, 3, 1));
		send_serial(serial_of(1900, 4, 30));
		send_serial(serial_of(1900, 12, 31));
		send_serial(serial_of(1901, 1, 1));
		send_serial(serial_of(1904, 2, 29));
		send_serial(serial_of(2000, 2, 29));
		send_serial(serial_of(2000, 12, 31));
		send_serial(serial_of(2100, 2, 28));
		send_serial(serial_of(2100, 3, 1));
	endtask

	task automatic test_upper_end();
		send_serial(serial_of(LAST_YEAR, 1, 1));
		send_serial(last_valid_serial);
		send_serial(last_valid_serial + 1);
		send_serial(MAX_SERIAL);
		send_serial(22'h2AAAAA);
		send_serial(22'h155555);
	endtask

	task automatic test_random_serials(input int count);
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 19);
			if (pick < 12)
				send_serial($urandom_range(3, last_valid_serial));
			else if (pick < 15)
				send_serial($urandom_range(3, 800));
			else if (pick < 16)
				send_serial($urandom_range(0, 2));
			else
				send_serial($urandom_range(0, MAX_SERIAL));
		end
	endtask

	initial begin
		last_valid_serial = serial_of(LAST_YEAR, 12, 31);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_low_serials();
		test_leap_rules();
		// hold off until the converter has drained
		wait_all_results();
		test_upper_end();
		test_random_serials(65);
		idle_on = 1'b0;
		test_random_serials(12);
		wait_all_results();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// time limit on the whole run, well beyond the slowest run
	initial begin
		#20000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
